// ===== rtl/dhcp_option_parser_top_defines.svh =====
// Assertion macros shared by the DHCP option parser RTL
`ifndef DHCP_OPTION_PARSER_TOP_DEFINES_SVH
`define DHCP_OPTION_PARSER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset
`define DOP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included
`define DOP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/dop_pkg.sv =====
// Types and option codes for the DHCP option parser
`default_nettype none

package dop_pkg;

    // Option parse phases
    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    // Option codes of interest
    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_NETMASK  = 8'd1;
    localparam logic [7:0] OPT_ROUTER   = 8'd3;
    localparam logic [7:0] OPT_DNS      = 8'd6;
    localparam logic [7:0] OPT_LEASE    = 8'd51;
    localparam logic [7:0] OPT_MSGTYPE  = 8'd53;
    localparam logic [7:0] OPT_SERVERID = 8'd54;
    localparam logic [7:0] OPT_END      = 8'd255;

    // Number of value bytes captured per option
    localparam logic [2:0] CAPTURE_BYTES = 3'd4;

    // One packet result
    typedef struct packed {
        logic [7:0]  message_type;
        logic [31:0] subnet_mask;
        logic [31:0] router_address;
        logic [31:0] dns_address;
        logic [31:0] server_identifier;
        logic [31:0] lease_seconds;
        logic        end_seen;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/dop_parse_core.sv =====
// Option walker: parse state, value capture and per-packet result
`default_nettype none
`include "dhcp_option_parser_top_defines.svh"

module dop_parse_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_last_byte,
    output logic                 o_res_valid,
    output dop_pkg::t_result     o_result
);

    dop_pkg::t_phase r_phase, n_phase, n_phase_step;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_bytes_rem, n_bytes_rem;
    logic [2:0]  r_value_pos, n_value_pos;
    logic [7:0]  r_type_seen, n_type_seen;
    logic [31:0] r_mask, n_mask;
    logic [31:0] r_router, n_router;
    logic [31:0] r_dns, n_dns;
    logic [31:0] r_server, n_server;
    logic [31:0] r_lease, n_lease;
    logic        r_end, n_end;
    logic [1:0]  lane;
    logic [4:0]  lane_lsb;

    // Byte lane for the current value position, first byte in bits 31..24
    assign lane     = 2'd3 - r_value_pos[1:0];
    assign lane_lsb = {lane, 3'b000};

    // Next parse phase for this byte
    always_comb begin
        n_phase_step = r_phase;
        unique case (r_phase)
            dop_pkg::PH_CODE: begin
                if (i_data_byte == dop_pkg::OPT_END) begin
                    n_phase_step = dop_pkg::PH_DONE;
                end else if (i_data_byte != dop_pkg::OPT_PAD) begin
                    n_phase_step = dop_pkg::PH_LEN;
                end
            end
            dop_pkg::PH_LEN: begin
                n_phase_step = (i_data_byte == 8'd0) ? dop_pkg::PH_CODE
                                                     : dop_pkg::PH_VALUE;
            end
            dop_pkg::PH_VALUE: begin
                if (r_bytes_rem == 8'd1) begin
                    n_phase_step = dop_pkg::PH_CODE;
                end
            end
            dop_pkg::PH_DONE: begin
                n_phase_step = dop_pkg::PH_DONE;
            end
            default: n_phase_step = dop_pkg::PH_CODE;
        endcase
        n_phase = i_last_byte ? dop_pkg::PH_CODE : n_phase_step;
    end

    // Capture lengths, value bytes and flags for this byte
    always_comb begin
        n_code      = r_code;
        n_bytes_rem = r_bytes_rem;
        n_value_pos = r_value_pos;
        n_type_seen = r_type_seen;
        n_mask      = r_mask;
        n_router    = r_router;
        n_dns       = r_dns;
        n_server    = r_server;
        n_lease     = r_lease;
        n_end       = r_end;
        unique case (r_phase)
            dop_pkg::PH_CODE: begin
                if (i_data_byte == dop_pkg::OPT_END) begin
                    n_end = 1'b1;
                end else if (i_data_byte != dop_pkg::OPT_PAD) begin
                    n_code = i_data_byte;
                end
            end
            dop_pkg::PH_LEN: begin
                n_bytes_rem = i_data_byte;
                n_value_pos = 3'd0;
            end
            dop_pkg::PH_VALUE: begin
                if (r_value_pos < dop_pkg::CAPTURE_BYTES) begin
                    unique case (r_code)
                        dop_pkg::OPT_NETMASK:  n_mask[lane_lsb +: 8]   = i_data_byte;
                        dop_pkg::OPT_ROUTER:   n_router[lane_lsb +: 8] = i_data_byte;
                        dop_pkg::OPT_DNS:      n_dns[lane_lsb +: 8]    = i_data_byte;
                        dop_pkg::OPT_SERVERID: n_server[lane_lsb +: 8] = i_data_byte;
                        dop_pkg::OPT_LEASE:    n_lease[lane_lsb +: 8]  = i_data_byte;
                        dop_pkg::OPT_MSGTYPE: begin
                            if (r_value_pos == 3'd0) begin
                                n_type_seen = i_data_byte;
                            end
                        end
                        default: ;
                    endcase
                    n_value_pos = r_value_pos + 3'd1;
                end
                n_bytes_rem = r_bytes_rem - 8'd1;
            end
            dop_pkg::PH_DONE: ;
            default: ;
        endcase
    end

    // Advance state on each accepted item; on the last byte clear parse state and flags, keep captured values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dop_pkg::PH_CODE;
            r_code      <= 8'd0;
            r_bytes_rem <= 8'd0;
            r_value_pos <= 3'd0;
            r_type_seen <= 8'd0;
            r_end       <= 1'b0;
            r_mask      <= 32'd0;
            r_router    <= 32'd0;
            r_dns       <= 32'd0;
            r_server    <= 32'd0;
            r_lease     <= 32'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_mask   <= n_mask;
            r_router <= n_router;
            r_dns    <= n_dns;
            r_server <= n_server;
            r_lease  <= n_lease;
            if (i_last_byte) begin
                r_code      <= 8'd0;
                r_bytes_rem <= 8'd0;
                r_value_pos <= 3'd0;
                r_type_seen <= 8'd0;
                r_end       <= 1'b0;
            end else begin
                r_code      <= n_code;
                r_bytes_rem <= n_bytes_rem;
                r_value_pos <= n_value_pos;
                r_type_seen <= n_type_seen;
                r_end       <= n_end;
            end
        end
    end

    // Result reflects the last byte already taken
    assign o_res_valid                = i_accept && i_last_byte;
    assign o_result.message_type      = n_type_seen;
    assign o_result.subnet_mask       = n_mask;
    assign o_result.router_address    = n_router;
    assign o_result.dns_address       = n_dns;
    assign o_result.server_identifier = n_server;
    assign o_result.lease_seconds     = n_lease;
    assign o_result.end_seen          = n_end;

    `DOP_ASSERT(a_pos_bound, i_clk, i_rst_n, r_value_pos <= dop_pkg::CAPTURE_BYTES, "value position past capture window")
    `DOP_ASSERT(a_value_rem, i_clk, i_rst_n, (r_phase == dop_pkg::PH_VALUE) |-> (r_bytes_rem != 8'd0), "value phase with no bytes left")
    `DOP_ASSERT(a_pkt_clear, i_clk, i_rst_n, (i_accept && i_last_byte) |=> (r_phase == dop_pkg::PH_CODE && !r_end && r_type_seen == 8'd0), "packet state not cleared after last byte")
    `DOP_ASSERT(a_done_end, i_clk, i_rst_n, (r_phase == dop_pkg::PH_DONE) |-> r_end, "done phase without end option")

endmodule

`default_nettype wire

// ===== rtl/dop_out_reg.sv =====
// Result register between the parser and the output channel
`default_nettype none
`include "dhcp_option_parser_top_defines.svh"

module dop_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire dop_pkg::t_result i_result,
    input  wire logic             i_take,
    output logic                  o_space,
    output logic                  o_valid,
    output dop_pkg::t_result      o_result
);

    logic             r_valid;
    dop_pkg::t_result r_result;

    // Hold the result until taken; a new one may replace it on the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_space  = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    `DOP_ASSERT(a_no_overrun, i_clk, i_rst_n, i_load |-> o_space, "result loaded over an untaken one")
    `DOP_ASSERT(a_hold, i_clk, i_rst_n, (r_valid && !i_take && !i_load) |=> (r_valid && $stable(r_result)), "pending result lost or changed")
    `DOP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !r_valid, "result pending after reset")

endmodule

`default_nettype wire

// ===== rtl/dhcp_option_parser_top.sv =====
// Top level of the DHCP option parser
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  in      | in  | i_valid / o_ready  | i_data_byte, i_last_byte
//  out     | out | o_valid / i_ready  | o_message_type, o_subnet_mask, ...,
//          |     |                    | o_lease_seconds, o_end_seen
//
// One byte is taken per cycle while o_ready is high; its effect on the parse state is final at the
// accepting edge, and a last byte loads the result register on that edge.
// A result appears on the output in the cycle after its last byte is accepted.
// Input stalls only while the result register holds an item not yet taken.
// Reset is synchronous, active low; it clears parse state, captured values and the pending flag.
`default_nettype none

module dhcp_option_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_message_type,
    output logic [31:0]      o_subnet_mask,
    output logic [31:0]      o_router_address,
    output logic [31:0]      o_dns_address,
    output logic [31:0]      o_server_identifier,
    output logic [31:0]      o_lease_seconds,
    output logic             o_end_seen
);

    logic             accept;
    logic             res_valid;
    logic             space;
    dop_pkg::t_result res_core;
    dop_pkg::t_result res_out;

    // Accept an item whenever the result register can take a result
    assign o_ready = space;
    assign accept  = i_valid && space;

    dop_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_res_valid (res_valid),
        .o_result    (res_core)
    );

    dop_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (res_core),
        .i_take   (i_ready),
        .o_space  (space),
        .o_valid  (o_valid),
        .o_result (res_out)
    );

    assign o_message_type      = res_out.message_type;
    assign o_subnet_mask       = res_out.subnet_mask;
    assign o_router_address    = res_out.router_address;
    assign o_dns_address       = res_out.dns_address;
    assign o_server_identifier = res_out.server_identifier;
    assign o_lease_seconds     = res_out.lease_seconds;
    assign o_end_seen          = res_out.end_seen;

endmodule

`default_nettype wire
